// ===== design/interval_coverage_table_assert.svh =====
// Assertion macros shared by the interval coverage table RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef INTERVAL_COVERAGE_TABLE_ASSERT_SVH
`define INTERVAL_COVERAGE_TABLE_ASSERT_SVH
`ifndef SYNTH
`define ICT_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("interval coverage table: assertion failed");
`define ICT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("interval coverage table: assertion failed");
`else
`define ICT_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ICT_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== design/ict_pkg.sv =====
// Types and constants of the interval coverage table.
// No dependencies; used by the cell, the cell row, the top level and the testbench.
`default_nettype none
package ict_pkg;

  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;
  localparam int          MASK_W    = 8;

  localparam logic OP_INSERT      = 1'b0;
  localparam logic OP_QUERY       = 1'b1;
  localparam logic MODE_CLASSICAL = 1'b0;
  localparam logic MODE_CANONICAL = 1'b1;

  // End points are held with the sign bit flipped so that unsigned
  // compares give the signed order.
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        mark;
  } cell_t;

  typedef struct packed {
    logic  pop;
    logic  push;
    cell_t pd;
  } ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ABSORB,
    ST_REBUILD,
    ST_FIND,
    ST_PLACE,
    ST_QUERY,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== design/ict_ifs.sv =====
// Handshake interfaces of the interval coverage table channels.
// Depends on nothing but the port widths fixed here.
`default_nettype none
interface ict_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [2:0]         attribute;
  logic signed [31:0] low_end;
  logic signed [31:0] high_end;
  modport source (output valid, operation, attribute, low_end, high_end, input ready);
  modport sink   (input valid, operation, attribute, low_end, high_end, output ready);
endinterface

interface ict_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] included_mask;
  logic       table_full;
  modport source (output valid, included_mask, table_full, input ready);
  modport sink   (input valid, included_mask, table_full, output ready);
endinterface

interface ict_cfg_if;
  logic valid;
  logic ready;
  logic cover_mode;
  modport source (output valid, cover_mode, input ready);
  modport sink   (input valid, cover_mode, output ready);
endinterface
`default_nettype wire

// ===== design/ict_cell.sv =====
// One cell of an attribute row: holds one interval and its scratch mark.
// Depends on ict_pkg for the cell type.
`default_nettype none
module ict_cell (
  input  wire logic          clk,
  input  wire logic          shift,
  input  wire logic          load,
  input  wire ict_pkg::cell_t ld_data,
  input  wire ict_pkg::cell_t nbr,
  output ict_pkg::cell_t     data
);

  ict_pkg::cell_t data_r;

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= ld_data;
    end else if (shift) begin
      data_r <= nbr;
    end
  end

  assign data = data_r;

endmodule
`default_nettype wire

// ===== design/ict_chain.sv =====
// Row of cells holding one attribute's table as a queue: pop at cell 0,
// push behind the last valid entry. Depends on ict_pkg and ict_cell.
`default_nettype none
module ict_chain #(
  parameter int ENTRIES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ict_pkg::ctl_t  ctl,
  output ict_pkg::cell_t      head,
  output logic [$clog2(ENTRIES+1)-1:0] len
);

  localparam int LW = $clog2(ENTRIES + 1);

  ict_pkg::cell_t cells [ENTRIES];
  logic [LW-1:0]  len_r, len_nxt, tgt;

  assign tgt     = ctl.pop ? len_r - LW'(1) : len_r;
  assign len_nxt = len_r + LW'(ctl.push) - LW'(ctl.pop);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ict_pkg::cell_t nbr;
    logic           ld;
    if (i == ENTRIES - 1) begin : g_last
      assign nbr = cells[i];
    end else begin : g_mid
      assign nbr = cells[i+1];
    end
    assign ld = ctl.push && (LW'(i) == tgt);
    ict_cell u_cell (
      .clk     (clk),
      .shift   (ctl.pop),
      .load    (ld),
      .ld_data (ctl.pd),
      .nbr     (nbr),
      .data    (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign head = cells[0];
  assign len  = len_r;

endmodule
`default_nettype wire

// ===== design/interval_coverage_table.sv =====
// Interval coverage table: per-attribute sorted interval tables with inserts
// and containment queries. Depends on ict_pkg, ict_ifs, ict_chain and the
// assertion macro header.
//
// Use: words arrive on in_ch (insert or query), one result word per input
// word leaves on out_ch, and cfg_ch writes cover_mode (reset value 1,
// canonical); cfg_ch is always ready. The user is to write cover_mode only
// while the block is idle; the block itself does not enforce it.
// Each table is a row of ENTRIES cells that rotates one entry per cycle past
// a shared insert engine and a query evaluator per attribute. A query scans
// all tables in parallel; a classical insert scans the addressed table once
// and then places the new entry; a canonical insert repeats absorbing scan
// passes until one absorbs nothing, then rebuilds the table.
// One word is worked on at a time; in_ch is ready only while idle.
// The result sits in an output register, so a new word is taken while the
// previous result waits; a stalled receiver holds the block in its last
// step until that register is free.
// Reset empties all tables and sets canonical mode.
`default_nettype none
`include "interval_coverage_table_assert.svh"
module interval_coverage_table #(
  parameter int ATTRS   = 8,
  parameter int ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ict_in_if.sink    in_ch,
  ict_out_if.source out_ch,
  ict_cfg_if.sink   cfg_ch
);

  localparam int LW = $clog2(ENTRIES + 1);

  ict_pkg::state_t state_r, state_nxt;
  logic            cover_mode_r;
  logic            op_r;
  logic [2:0]      attr_r;
  logic [31:0]     nl_r, nh_r;
  logic [LW-1:0]   k_r, cnt_r, absn_r;
  logic            first_r, changed_r, placed_r, found_r, full_r;
  logic            out_valid_r, out_full_r;
  logic [ict_pkg::MASK_W-1:0] out_mask_r, res_mask;

  ict_pkg::cell_t heads [ATTRS];
  logic [LW-1:0]  lens  [ATTRS];
  ict_pkg::cell_t head_sel, h_new;
  logic [LW-1:0]  len_sel;
  ict_pkg::ctl_t  eng_ctl;
  logic           attr_ok, ins_state, in_acc, out_free, mk, hit;
  logic           q_found [ATTRS];
  logic           q_cov   [ATTRS];
  logic [31:0]    q_blo   [ATTRS];
  logic [31:0]    q_bhi   [ATTRS];

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign attr_ok   = int'(attr_r) < ATTRS;
  assign ins_state = (state_r == ict_pkg::ST_ABSORB) || (state_r == ict_pkg::ST_REBUILD) ||
                     (state_r == ict_pkg::ST_FIND) || (state_r == ict_pkg::ST_PLACE);

  always_comb begin
    head_sel = '0;
    len_sel  = '0;
    for (int j = 0; j < ATTRS; j++) begin
      if (int'(attr_r) == j) begin
        head_sel = heads[j];
        len_sel  = lens[j];
      end
    end
  end

  // Stale marks from an earlier insert are ignored on the first scan pass.
  assign mk    = first_r ? 1'b0 : head_sel.mark;
  assign hit   = !mk && (head_sel.hi >= nl_r) && (head_sel.lo <= nh_r);
  assign h_new = '{lo: nl_r, hi: nh_r, mark: 1'b0};

  for (genvar j = 0; j < ATTRS; j++) begin : g_attr
    ict_pkg::ctl_t ctl;
    logic          qrot;
    assign qrot = (state_r == ict_pkg::ST_QUERY) && (k_r < lens[j]);
    always_comb begin
      if (ins_state && (int'(attr_r) == j)) begin
        ctl = eng_ctl;
      end else begin
        ctl = '{pop: qrot, push: qrot, pd: heads[j]};
      end
    end
    ict_chain #(.ENTRIES(ENTRIES)) u_chain (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .head  (heads[j]),
      .len   (lens[j])
    );
    always_ff @(posedge clk) begin
      if (state_r == ict_pkg::ST_START) begin
        q_found[j] <= 1'b0;
        q_cov[j]   <= 1'b0;
      end else if (qrot) begin
        if (heads[j].lo <= nl_r && nh_r <= heads[j].hi) begin
          q_cov[j] <= 1'b1;
        end
        if (heads[j].lo <= nl_r && (!q_found[j] || heads[j].lo >= q_blo[j])) begin
          q_found[j] <= 1'b1;
          q_blo[j]   <= heads[j].lo;
          q_bhi[j]   <= heads[j].hi;
        end
      end
    end
  end

  always_comb begin
    res_mask = '0;
    for (int j = 0; j < ict_pkg::MASK_W; j++) begin
      if (j < ATTRS) begin
        if (cover_mode_r == ict_pkg::MODE_CANONICAL) begin
          res_mask[j] = q_cov[j];
        end else begin
          res_mask[j] = q_found[j] && (q_bhi[j] >= nh_r);
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ict_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = ict_pkg::ST_START;
      end
      ict_pkg::ST_START: begin
        if (op_r == ict_pkg::OP_QUERY) begin
          state_nxt = ict_pkg::ST_QUERY;
        end else if (!attr_ok) begin
          state_nxt = ict_pkg::ST_DONE;
        end else if (cover_mode_r == ict_pkg::MODE_CANONICAL) begin
          state_nxt = ict_pkg::ST_ABSORB;
        end else begin
          state_nxt = ict_pkg::ST_FIND;
        end
      end
      ict_pkg::ST_ABSORB: begin
        if (k_r == '0 && !changed_r) begin
          if (cnt_r - absn_r == LW'(ENTRIES)) state_nxt = ict_pkg::ST_DONE;
          else state_nxt = ict_pkg::ST_REBUILD;
        end
      end
      ict_pkg::ST_REBUILD, ict_pkg::ST_PLACE: begin
        if (k_r == '0) state_nxt = ict_pkg::ST_DONE;
      end
      ict_pkg::ST_FIND: begin
        if (k_r == '0) begin
          if (found_r || cnt_r == LW'(ENTRIES)) state_nxt = ict_pkg::ST_DONE;
          else state_nxt = ict_pkg::ST_PLACE;
        end
      end
      ict_pkg::ST_QUERY: begin
        if (k_r == LW'(ENTRIES)) state_nxt = ict_pkg::ST_DONE;
      end
      ict_pkg::ST_DONE: begin
        if (out_free) state_nxt = ict_pkg::ST_IDLE;
      end
      default: state_nxt = ict_pkg::ST_IDLE;
    endcase
  end

  // Engine commands to the addressed row.
  always_comb begin
    eng_ctl = '{pop: 1'b0, push: 1'b0, pd: head_sel};
    unique case (state_r)
      ict_pkg::ST_ABSORB: begin
        if (k_r != '0) begin
          eng_ctl = '{pop: 1'b1, push: 1'b1,
                      pd: '{lo: head_sel.lo, hi: head_sel.hi, mark: mk || hit}};
        end
      end
      ict_pkg::ST_REBUILD, ict_pkg::ST_PLACE: begin
        if (k_r == '0) begin
          eng_ctl = '{pop: 1'b0, push: !placed_r, pd: h_new};
        end else if (state_r == ict_pkg::ST_REBUILD && head_sel.mark) begin
          eng_ctl.pop = 1'b1;
        end else if (!placed_r && head_sel.lo > nl_r) begin
          eng_ctl = '{pop: 1'b0, push: 1'b1, pd: h_new};
        end else begin
          eng_ctl = '{pop: 1'b1, push: 1'b1,
                      pd: '{lo: head_sel.lo, hi: head_sel.hi, mark: 1'b0}};
        end
      end
      ict_pkg::ST_FIND: begin
        if (k_r != '0) begin
          eng_ctl.pop  = 1'b1;
          eng_ctl.push = 1'b1;
          if (!found_r && head_sel.lo == nl_r && nh_r > head_sel.hi) begin
            eng_ctl.pd.hi = nh_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ict_pkg::ST_IDLE;
      cover_mode_r <= ict_pkg::MODE_CANONICAL;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) cover_mode_r <= cfg_ch.cover_mode;
      if (state_r == ict_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ict_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_r   <= in_ch.operation;
          attr_r <= in_ch.attribute;
          full_r <= 1'b0;
          if (in_ch.operation == ict_pkg::OP_QUERY ||
              (unsigned'(in_ch.low_end) ^ ict_pkg::SIGN_FLIP) <=
              (unsigned'(in_ch.high_end) ^ ict_pkg::SIGN_FLIP)) begin
            nl_r <= unsigned'(in_ch.low_end) ^ ict_pkg::SIGN_FLIP;
            nh_r <= unsigned'(in_ch.high_end) ^ ict_pkg::SIGN_FLIP;
          end else begin
            nl_r <= unsigned'(in_ch.high_end) ^ ict_pkg::SIGN_FLIP;
            nh_r <= unsigned'(in_ch.low_end) ^ ict_pkg::SIGN_FLIP;
          end
        end
      end
      ict_pkg::ST_START: begin
        k_r       <= (op_r == ict_pkg::OP_QUERY) ? '0 : len_sel;
        cnt_r     <= len_sel;
        first_r   <= 1'b1;
        changed_r <= 1'b0;
        absn_r    <= '0;
        found_r   <= 1'b0;
        placed_r  <= 1'b0;
      end
      ict_pkg::ST_ABSORB: begin
        if (k_r != '0) begin
          k_r <= k_r - LW'(1);
          if (hit) begin
            changed_r <= 1'b1;
            absn_r    <= absn_r + LW'(1);
            if (head_sel.lo < nl_r) nl_r <= head_sel.lo;
            if (head_sel.hi > nh_r) nh_r <= head_sel.hi;
          end
        end else if (changed_r) begin
          k_r       <= cnt_r;
          first_r   <= 1'b0;
          changed_r <= 1'b0;
        end else begin
          k_r    <= cnt_r;
          full_r <= (cnt_r - absn_r == LW'(ENTRIES));
        end
      end
      ict_pkg::ST_REBUILD, ict_pkg::ST_PLACE: begin
        if (k_r != '0) begin
          if (eng_ctl.pop) k_r <= k_r - LW'(1);
          if (eng_ctl.push && !eng_ctl.pop) placed_r <= 1'b1;
        end
      end
      ict_pkg::ST_FIND: begin
        if (k_r != '0) begin
          k_r <= k_r - LW'(1);
          if (head_sel.lo == nl_r) found_r <= 1'b1;
        end else begin
          k_r    <= cnt_r;
          full_r <= !found_r && (cnt_r == LW'(ENTRIES));
        end
      end
      ict_pkg::ST_QUERY: begin
        k_r <= k_r + LW'(1);
      end
      ict_pkg::ST_DONE: begin
        if (out_free) begin
          out_mask_r <= (op_r == ict_pkg::OP_QUERY) ? res_mask : '0;
          out_full_r <= (op_r == ict_pkg::OP_QUERY) ? 1'b0 : full_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready          = (state_r == ict_pkg::ST_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.included_mask = out_mask_r;
  assign out_ch.table_full    = out_full_r;

  `ICT_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_acc, state_r != ict_pkg::ST_IDLE)
  `ICT_ASSERT_IMPL(a_full_no_mask, clk, rst_n, out_valid_r && out_full_r, out_mask_r == '0)
  `ICT_ASSERT_IMPL(a_abs_bound, clk, rst_n, state_r == ict_pkg::ST_ABSORB, absn_r <= cnt_r)

endmodule
`default_nettype wire

// ===== tb/ict_scoreboard.sv =====
// Checker for the interval coverage table: watches all three channels, keeps
// its own copy of the interval tables and compares every result word.
// Depends on ict_pkg and the channel interfaces in ict_ifs.
`default_nettype none
module ict_scoreboard (
  input  wire logic clk,
  input  wire logic rst_n,
  ict_in_if         in_ch,
  ict_out_if        out_ch,
  ict_cfg_if        cfg_ch,
  output int        fails,
  output int        pending
);

  localparam int N_ATTR = 8;
  localparam int N_ENT  = 64;

  typedef struct {
    logic [7:0] mask;
    logic       full;
  } result_t;

  // End points are kept sign-flipped so that unsigned compares order them.
  logic [31:0] tab_lo [N_ATTR][N_ENT];
  logic [31:0] tab_hi [N_ATTR][N_ENT];
  int unsigned tab_cnt [N_ATTR];
  logic        mode_q;
  result_t     expected_results[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  function automatic logic merge_insert(input int t, input logic [31:0] lo_in,
                                        input logic [31:0] hi_in);
    logic [31:0] nl, nh;
    logic [31:0] nlo [N_ENT];
    logic [31:0] nhi [N_ENT];
    bit          gone [N_ENT];
    bit          grew, placed;
    int unsigned kept, n;
    nl = lo_in;
    nh = hi_in;
    kept = 0;
    n = 0;
    placed = 0;
    grew = 1;
    for (int i = 0; i < N_ENT; i++) gone[i] = 0;
    // The union can grow onto entries skipped earlier, so scan until stable.
    while (grew) begin
      grew = 0;
      for (int i = 0; i < tab_cnt[t]; i++) begin
        if (!gone[i] && tab_hi[t][i] >= nl && tab_lo[t][i] <= nh) begin
          gone[i] = 1;
          if (tab_lo[t][i] < nl) nl = tab_lo[t][i];
          if (tab_hi[t][i] > nh) nh = tab_hi[t][i];
          grew = 1;
        end
      end
    end
    for (int i = 0; i < tab_cnt[t]; i++) if (!gone[i]) kept++;
    if (kept + 1 > N_ENT) return 1'b1;
    for (int i = 0; i < tab_cnt[t]; i++) begin
      if (!gone[i]) begin
        if (!placed && tab_lo[t][i] > nl) begin
          nlo[n] = nl; nhi[n] = nh; n++; placed = 1;
        end
        nlo[n] = tab_lo[t][i]; nhi[n] = tab_hi[t][i]; n++;
      end
    end
    if (!placed) begin
      nlo[n] = nl; nhi[n] = nh; n++;
    end
    for (int i = 0; i < n; i++) begin
      tab_lo[t][i] = nlo[i];
      tab_hi[t][i] = nhi[i];
    end
    tab_cnt[t] = n;
    return 1'b0;
  endfunction

  function automatic logic sorted_insert(input int t, input logic [31:0] nl,
                                         input logic [31:0] nh);
    int unsigned pos;
    for (int i = 0; i < tab_cnt[t]; i++) begin
      if (tab_lo[t][i] == nl) begin
        if (nh > tab_hi[t][i]) tab_hi[t][i] = nh;
        return 1'b0;
      end
    end
    if (tab_cnt[t] >= N_ENT) return 1'b1;
    pos = tab_cnt[t];
    for (int i = 0; i < tab_cnt[t]; i++) begin
      if (tab_lo[t][i] > nl) begin
        pos = i;
        break;
      end
    end
    for (int i = tab_cnt[t]; i > pos; i--) begin
      tab_lo[t][i] = tab_lo[t][i-1];
      tab_hi[t][i] = tab_hi[t][i-1];
    end
    tab_lo[t][pos] = nl;
    tab_hi[t][pos] = nh;
    tab_cnt[t]++;
    return 1'b0;
  endfunction

  function automatic logic is_covered(input int t, input logic [31:0] a, input logic [31:0] b);
    int  best;
    bit  found;
    best = 0;
    found = 0;
    if (mode_q == ict_pkg::MODE_CANONICAL) begin
      for (int i = 0; i < tab_cnt[t]; i++)
        if (tab_lo[t][i] <= a && b <= tab_hi[t][i]) return 1'b1;
      return 1'b0;
    end
    // Later entries win on equal low ends, which only a mode change can leave.
    for (int i = 0; i < tab_cnt[t]; i++) begin
      if (tab_lo[t][i] <= a && (!found || tab_lo[t][i] >= tab_lo[t][best])) begin
        best = i;
        found = 1;
      end
    end
    return found && tab_hi[t][best] >= b;
  endfunction

  function automatic result_t predict_word(input logic op, input logic [2:0] attr,
                                           input logic [31:0] lo_raw, input logic [31:0] hi_raw);
    result_t     r;
    logic [31:0] a, b;
    a = lo_raw ^ ict_pkg::SIGN_FLIP;
    b = hi_raw ^ ict_pkg::SIGN_FLIP;
    r.mask = '0;
    r.full = 1'b0;
    if (op == ict_pkg::OP_INSERT) begin
      if (mode_q == ict_pkg::MODE_CANONICAL)
        r.full = merge_insert(int'(attr), (a < b) ? a : b, (a < b) ? b : a);
      else
        r.full = sorted_insert(int'(attr), (a < b) ? a : b, (a < b) ? b : a);
    end else begin
      for (int j = 0; j < N_ATTR; j++) r.mask[j] = is_covered(j, a, b);
    end
    return r;
  endfunction

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int t = 0; t < N_ATTR; t++) tab_cnt[t] = 0;
      mode_q = ict_pkg::MODE_CANONICAL;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected word", {23'b0, out_ch.table_full, out_ch.included_mask}, 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.included_mask !== want.mask)
            report("included_mask", 32'(out_ch.included_mask), 32'(want.mask));
          if (out_ch.table_full !== want.full)
            report("table_full", 32'(out_ch.table_full), 32'(want.full));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) mode_q = cfg_ch.cover_mode;
      if (in_ch.valid && in_ch.ready)
        expected_results = {expected_results,
                            predict_word(in_ch.operation, in_ch.attribute,
                                         in_ch.low_end, in_ch.high_end)};
    end
    pending = expected_results.size();
  end

endmodule
`default_nettype wire

// ===== tb/tb_interval_coverage_table.sv =====
// Top of the interval coverage table testbench: clock, reset, stimulus and
// verdict. Depends on ict_pkg, ict_ifs, the block and ict_scoreboard.
`default_nettype none
module tb_interval_coverage_table;

  localparam int CYCLE_LIMIT = 4_000_000;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   cycles;
  int   words_sent;
  int   mode_writes;
  int   send_idle_pct;
  int   recv_idle_pct;

  ict_in_if  in_ch();
  ict_out_if out_ch();
  ict_cfg_if cfg_ch();

  interval_coverage_table dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  ict_scoreboard checker_i (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .fails  (fails),
    .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic signed [31:0] q16(input int v);
    return v <<< 16;
  endfunction

  // Mostly small whole values so that intervals overlap, with the odd
  // extreme or fully random end point.
  function automatic logic signed [31:0] pick_end();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom;
    if (r < 13) return 32'sh7fff_ffff;
    if (r < 16) return 32'sh8000_0000;
    if (r < 25) return q16($urandom_range(80) - 40) + $urandom_range(65535);
    return q16($urandom_range(80) - 40);
  endfunction

  task automatic send_word(input logic op, input logic [2:0] attr,
                           input logic signed [31:0] lo, input logic signed [31:0] hi);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.attribute <= attr;
    in_ch.low_end   <= lo;
    in_ch.high_end  <= hi;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.cover_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    mode_writes++;
  endtask

  task automatic random_words(input int n);
    logic signed [31:0] a, b, t;
    for (int i = 0; i < n; i++) begin
      a = pick_end();
      b = pick_end();
      // Ends are mostly put in order; inserts and queries alike are sometimes left inverted.
      if ($urandom_range(99) < 85 && a > b) begin
        t = a; a = b; b = t;
      end
      if ($urandom_range(99) < 55)
        send_word(ict_pkg::OP_INSERT, 3'($urandom_range(7)), a, b);
      else
        send_word(ict_pkg::OP_QUERY, 3'($urandom_range(7)), a, b);
    end
  endtask

  // Disjoint, non-touching intervals until the table overflows.
  task automatic overfill(input logic [2:0] attr, input int base);
    for (int i = 0; i < 68; i++) begin
      send_word(ict_pkg::OP_INSERT, attr, q16(base + 3 * i), q16(base + 3 * i) + 32'sh8000);
      if (i % 8 == 0)
        send_word(ict_pkg::OP_QUERY, 3'd0, q16(base + 3 * i), q16(base + 3 * i) + 1);
    end
    send_word(ict_pkg::OP_QUERY, 3'd0, q16(base), q16(base) + 32'sh100);
  endtask

  initial begin
    cycles = 0;
    words_sent = 0;
    mode_writes = 0;
    send_idle_pct = 27;
    recv_idle_pct = 60;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= ict_pkg::OP_INSERT;
    in_ch.attribute <= '0;
    in_ch.low_end <= '0;
    in_ch.high_end <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.cover_mode <= ict_pkg::MODE_CANONICAL;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Canonical mode from reset: extremes, touching fusion, inverted ends.
    send_word(ict_pkg::OP_QUERY,  3'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_word(ict_pkg::OP_INSERT, 3'd0, 32'sh8000_0000, 32'sh8000_0000);
    send_word(ict_pkg::OP_INSERT, 3'd7, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_word(ict_pkg::OP_QUERY,  3'd3, 32'sh8000_0000, 32'sh8000_0000);
    send_word(ict_pkg::OP_QUERY,  3'd3, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_word(ict_pkg::OP_INSERT, 3'd1, q16(10), q16(20));
    send_word(ict_pkg::OP_INSERT, 3'd1, q16(20), q16(30));
    send_word(ict_pkg::OP_QUERY,  3'd1, q16(12), q16(28));
    send_word(ict_pkg::OP_INSERT, 3'd2, q16(50), q16(40));
    send_word(ict_pkg::OP_QUERY,  3'd2, q16(45), q16(42));
    send_word(ict_pkg::OP_QUERY,  3'd2, q16(40), q16(50));
    send_word(ict_pkg::OP_INSERT, 3'd3, q16(-5), q16(5));
    send_word(ict_pkg::OP_INSERT, 3'd1, q16(0), q16(9));
    send_word(ict_pkg::OP_QUERY,  3'd5, q16(0), q16(0));
    random_words(120);
    // Let every result come home before carrying on.
    drain();
    random_words(120);
    overfill(3'd6, 500);
    drain();

    write_mode(ict_pkg::MODE_CLASSICAL);
    send_idle_pct = 60;
    recv_idle_pct = 27;
    send_word(ict_pkg::OP_INSERT, 3'd4, q16(0), q16(10));
    send_word(ict_pkg::OP_INSERT, 3'd4, q16(0), q16(5));
    send_word(ict_pkg::OP_QUERY,  3'd4, q16(3), q16(9));
    send_word(ict_pkg::OP_QUERY,  3'd4, q16(-100), q16(-99));
    send_word(ict_pkg::OP_INSERT, 3'd4, q16(20), q16(15));
    send_word(ict_pkg::OP_QUERY,  3'd4, q16(16), q16(19));
    random_words(100);
    overfill(3'd5, 700);
    drain();

    write_mode(ict_pkg::MODE_CANONICAL);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_words(80);
    drain();
    write_mode(ict_pkg::MODE_CLASSICAL);
    random_words(60);
    drain();
    write_mode(ict_pkg::MODE_CANONICAL);
    random_words(60);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d words over %0d mode writes, both modes, full tables and extremes",
             words_sent, mode_writes);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/ict_pkg.sv
design/ict_ifs.sv
design/ict_cell.sv
design/ict_chain.sv
design/interval_coverage_table.sv
tb/ict_scoreboard.sv
tb/tb_interval_coverage_table.sv
